@@ hw/rtl/linear_probe_hash_table_assert.svh @@
// Assertion macros for the hash table block.
// Used by lpht_back through `include; compiled out under SYNTHESIS.
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define LPHT_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("lpht assertion failed");
`define LPHT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpht assertion failed");
`else
`define LPHT_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define LPHT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/lpht_pkg.sv @@
// Shared types and constants of the hash table block.
// No dependencies.
`default_nettype none
package lpht_pkg;
  localparam int TABLE_SLOTS = 256;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int COUNT_W     = $clog2(TABLE_SLOTS + 1);
  localparam int KEY_W       = 64;
  localparam int VAL_W       = 64;
  localparam int IDX_W       = 8;
  localparam int KEY_BYTES   = 8;
  localparam int HASH_SEED   = 42;
  localparam int QDEPTH      = 2;
  localparam int HSTEPS      = 6;
  localparam int HSTEP_W     = $clog2(HSTEPS);

  // seed ^ key length, also the initial h2
  localparam logic [63:0] SEED_MIX = 64'(HASH_SEED ^ KEY_BYTES);

  localparam logic [63:0] MUL_C [HSTEPS] = '{
    64'h87c37b91114253d5, 64'h4cf5ad432745937f,
    64'hff51afd7ed558ccd, 64'hc4ceb9fe1a85ec53,
    64'hff51afd7ed558ccd, 64'hc4ceb9fe1a85ec53
  };

  typedef enum logic [1:0] {
    CMD_INSERT, CMD_REMOVE, CMD_LOOKUP, CMD_UPDATE
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK, ST_NOT_FOUND, ST_PRESENT, ST_FULL, ST_EMPTY_KEY
  } status_t;

  typedef enum logic [1:0] {F_IDLE, F_HASH, F_PUSH} front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_FIND, B_VAL, B_ERASE, B_MOVE, B_RESP
  } back_state_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic [SLOT_W-1:0] home;
    logic              empty_key;
  } job_t;

  typedef struct packed {
    logic [SLOT_W-1:0] home;
    logic [KEY_W-1:0]  key;
  } slot_rec_t;
endpackage
`default_nettype wire

@@ hw/rtl/lpht_if.sv @@
// Valid/ready channel interfaces for commands and results.
// Depends on nothing.
`default_nettype none
interface lpht_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [63:0] key;
  logic [63:0] value;
  modport source (output valid, cmd, key, value, input ready);
  modport sink (input valid, cmd, key, value, output ready);
endinterface

interface lpht_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] value_out;
  logic [7:0]  slot_index;
  logic [8:0]  entry_count;
  modport source (output valid, status, value_out, slot_index, entry_count, input ready);
  modport sink (input valid, status, value_out, slot_index, entry_count, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/lpht_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lpht_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule
`default_nettype wire

@@ hw/rtl/lpht_front.sv @@
// Front end: accepts an item, flags empty keys and computes the home slot
// with a 32x32 multiplier shared over three partial products per 64-bit product.
// Depends on lpht_pkg and lpht_if.
`default_nettype none
module lpht_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  lpht_in_if.sink            in_itm,
  output logic               push_valid,
  input  wire logic          push_ready,
  output lpht_pkg::job_t     push_job
);
  lpht_pkg::front_state_t state_r, state_nxt;
  lpht_pkg::job_t         job_r, job_nxt;
  logic [63:0] x_r, x_nxt, acc_r, acc_nxt, h2_r, h2_nxt, f1_r, f1_nxt;
  logic [lpht_pkg::HSTEP_W-1:0] mi_r, mi_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [63:0] op_a, op_b, prod, fin, fx;
  logic [31:0] ma, mb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpht_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    job_r <= job_nxt;
    x_r   <= x_nxt;
    acc_r <= acc_nxt;
    h2_r  <= h2_nxt;
    f1_r  <= f1_nxt;
    mi_r  <= mi_nxt;
    ph_r  <= ph_nxt;
  end

  always_comb begin
    // fmix steps take x ^ (x >> 33) as multiplicand
    op_a = ((mi_r == 3'd2) || (mi_r == 3'd4)) ? (x_r ^ (x_r >> 33)) : x_r;
    op_b = lpht_pkg::MUL_C[mi_r];
    case (ph_r)
      2'd0:    begin ma = op_a[31:0];  mb = op_b[31:0];  end
      2'd1:    begin ma = op_a[31:0];  mb = op_b[63:32]; end
      default: begin ma = op_a[63:32]; mb = op_b[31:0];  end
    endcase
    prod = 64'(ma) * 64'(mb);
    fin  = acc_r + {prod[31:0], 32'h0};
    fx   = fin ^ (fin >> 33);
  end

  always_comb begin
    state_nxt  = state_r;
    job_nxt    = job_r;
    x_nxt      = x_r;
    acc_nxt    = acc_r;
    h2_nxt     = h2_r;
    f1_nxt     = f1_r;
    mi_nxt     = mi_r;
    ph_nxt     = ph_r;
    push_valid = 1'b0;
    in_itm.ready = (state_r == lpht_pkg::F_IDLE);
    unique case (state_r)
      lpht_pkg::F_IDLE: begin
        if (in_itm.valid) begin
          job_nxt.cmd       = lpht_pkg::cmd_t'(in_itm.cmd);
          job_nxt.key       = in_itm.key;
          job_nxt.value     = in_itm.value;
          job_nxt.home      = '0;
          job_nxt.empty_key = (in_itm.key[7:0] == 8'h00);
          x_nxt  = in_itm.key;
          mi_nxt = '0;
          ph_nxt = '0;
          state_nxt = (in_itm.key[7:0] == 8'h00) ? lpht_pkg::F_PUSH : lpht_pkg::F_HASH;
        end
      end
      lpht_pkg::F_HASH: begin
        if (ph_r == 2'd0) begin
          acc_nxt = prod;
          ph_nxt  = 2'd1;
          if (mi_r == 3'd2) begin
            h2_nxt = x_r + lpht_pkg::SEED_MIX;
          end
        end else if (ph_r == 2'd1) begin
          acc_nxt = fin;
          ph_nxt  = 2'd2;
        end else begin
          ph_nxt = 2'd0;
          mi_nxt = mi_r + 1'b1;
          case (mi_r)
            3'd0: x_nxt = {fin[32:0], fin[63:33]};
            3'd1: x_nxt = (fin ^ lpht_pkg::SEED_MIX) + lpht_pkg::SEED_MIX;
            3'd3: begin
              f1_nxt = fx;
              x_nxt  = h2_r;
            end
            3'd5: begin
              job_nxt.home = f1_r[lpht_pkg::SLOT_W-1:0] + fx[lpht_pkg::SLOT_W-1:0];
              state_nxt    = lpht_pkg::F_PUSH;
            end
            default: x_nxt = fx;
          endcase
        end
      end
      lpht_pkg::F_PUSH: begin
        push_valid = 1'b1;
        if (push_ready) begin
          state_nxt = lpht_pkg::F_IDLE;
        end
      end
      default: state_nxt = lpht_pkg::F_IDLE;
    endcase
  end

  assign push_job = job_r;
endmodule
`default_nettype wire

@@ hw/rtl/lpht_queue.sv @@
// Short job queue between the hashing front end and the table engine.
// Depends on lpht_pkg.
`default_nettype none
module lpht_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire lpht_pkg::job_t push_job,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output lpht_pkg::job_t     pop_job
);
  localparam int PW = $clog2(lpht_pkg::QDEPTH);
  localparam int CW = $clog2(lpht_pkg::QDEPTH + 1);

  lpht_pkg::job_t  mem_r [lpht_pkg::QDEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign push_ready = (cnt_r != CW'(lpht_pkg::QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_job    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(lpht_pkg::QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(lpht_pkg::QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(do_push) - CW'(do_pop);
    end
    if (do_push) begin
      mem_r[wp_r] <= push_job;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/lpht_back.sv @@
// Table engine: probe walk, insert, update, lookup and backward-shift remove
// over key and value RAMs, plus the result register.
// Depends on lpht_pkg, lpht_if, lpht_ram and the assertion header.
`default_nettype none
`include "linear_probe_hash_table_assert.svh"
module lpht_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           pop_valid,
  output logic                pop_ready,
  input  wire lpht_pkg::job_t pop_job,
  lpht_out_if.source          out_itm
);
  localparam int SW = lpht_pkg::SLOT_W;
  localparam int CW = lpht_pkg::COUNT_W;
  localparam int RW = $bits(lpht_pkg::slot_rec_t);

  lpht_pkg::back_state_t state_r, state_nxt;
  lpht_pkg::job_t        job_r, job_nxt;
  lpht_pkg::status_t     status_r, status_nxt;
  lpht_pkg::slot_rec_t   cand_r, cand_nxt, krec;
  logic [SW-1:0]  s_r, s_nxt, hole_r, hole_nxt, slot_r, slot_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [lpht_pkg::TABLE_SLOTS-1:0] valid_r, valid_nxt;
  logic           vrd_r;
  logic [63:0]    vout_r, vout_nxt;

  logic           kwe, vwe;
  logic [SW-1:0]  kwaddr, vwaddr;
  logic [RW-1:0]  kwdata, krdata;
  logic [63:0]    vwdata, vrdata;

  logic           out_valid_r;
  logic [2:0]     out_status_r;
  logic [63:0]    out_vout_r;
  logic [7:0]     out_slot_r;
  logic [8:0]     out_count_r;
  logic           load_out;

  lpht_ram #(.WIDTH(RW), .DEPTH(lpht_pkg::TABLE_SLOTS)) u_key_ram (
    .clk(clk), .we(kwe), .waddr(kwaddr), .wdata(kwdata), .raddr(s_nxt), .rdata(krdata)
  );

  lpht_ram #(.WIDTH(64), .DEPTH(lpht_pkg::TABLE_SLOTS)) u_val_ram (
    .clk(clk), .we(vwe), .waddr(vwaddr), .wdata(vwdata), .raddr(s_r), .rdata(vrdata)
  );

  assign krec = lpht_pkg::slot_rec_t'(krdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpht_pkg::B_IDLE;
      count_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_itm.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    job_r    <= job_nxt;
    status_r <= status_nxt;
    cand_r   <= cand_nxt;
    s_r      <= s_nxt;
    hole_r   <= hole_nxt;
    slot_r   <= slot_nxt;
    vout_r   <= vout_nxt;
    vrd_r    <= valid_r[s_nxt];
    if (load_out) begin
      out_status_r <= status_r;
      out_vout_r   <= vout_r;
      out_slot_r   <= 8'(slot_r);
      out_count_r  <= 9'(count_r);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    job_nxt    = job_r;
    status_nxt = status_r;
    cand_nxt   = cand_r;
    s_nxt      = s_r;
    hole_nxt   = hole_r;
    slot_nxt   = slot_r;
    count_nxt  = count_r;
    valid_nxt  = valid_r;
    vout_nxt   = vout_r;
    pop_ready  = 1'b0;
    load_out   = 1'b0;
    kwe    = 1'b0;
    kwaddr = s_r;
    kwdata = {job_r.home, job_r.key};
    vwe    = 1'b0;
    vwaddr = s_r;
    vwdata = job_r.value;
    unique case (state_r)
      lpht_pkg::B_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          job_nxt    = pop_job;
          s_nxt      = pop_job.home;
          slot_nxt   = '0;
          vout_nxt   = '0;
          status_nxt = lpht_pkg::ST_OK;
          if (pop_job.empty_key) begin
            status_nxt = lpht_pkg::ST_EMPTY_KEY;
            state_nxt  = lpht_pkg::B_RESP;
          end else begin
            state_nxt = lpht_pkg::B_FIND;
          end
        end
      end
      lpht_pkg::B_FIND: begin
        if (!vrd_r) begin
          state_nxt = lpht_pkg::B_RESP;
          if (job_r.cmd != lpht_pkg::CMD_INSERT) begin
            status_nxt = lpht_pkg::ST_NOT_FOUND;
          end else if ({1'b0, count_r} + 1'b1 >= (CW+1)'(lpht_pkg::TABLE_SLOTS)) begin
            status_nxt = lpht_pkg::ST_FULL;
          end else begin
            // first free slot of the walk is where the key goes
            kwe          = 1'b1;
            vwe          = 1'b1;
            valid_nxt[s_r] = 1'b1;
            count_nxt    = count_r + 1'b1;
            slot_nxt     = s_r;
          end
        end else if (krec.key == job_r.key) begin
          slot_nxt = s_r;
          unique case (job_r.cmd)
            lpht_pkg::CMD_INSERT: begin
              status_nxt = lpht_pkg::ST_PRESENT;
              slot_nxt   = '0;
              state_nxt  = lpht_pkg::B_RESP;
            end
            lpht_pkg::CMD_LOOKUP: state_nxt = lpht_pkg::B_VAL;
            lpht_pkg::CMD_UPDATE: begin
              vwe       = 1'b1;
              state_nxt = lpht_pkg::B_RESP;
            end
            default: begin
              valid_nxt[s_r] = 1'b0;
              hole_nxt  = s_r;
              count_nxt = count_r - 1'b1;
              s_nxt     = s_r + 1'b1;
              state_nxt = lpht_pkg::B_ERASE;
            end
          endcase
        end else begin
          s_nxt = s_r + 1'b1;
        end
      end
      lpht_pkg::B_VAL: begin
        vout_nxt  = vrdata;
        state_nxt = lpht_pkg::B_RESP;
      end
      lpht_pkg::B_ERASE: begin
        if (!vrd_r) begin
          state_nxt = lpht_pkg::B_RESP;
        end else begin
          cand_nxt = krec;
          // move back unless home lies after the hole, up to this slot
          if ((s_r - krec.home) >= (s_r - hole_r)) begin
            state_nxt = lpht_pkg::B_MOVE;
          end else begin
            s_nxt = s_r + 1'b1;
          end
        end
      end
      lpht_pkg::B_MOVE: begin
        kwe    = 1'b1;
        kwaddr = hole_r;
        kwdata = cand_r;
        vwe    = 1'b1;
        vwaddr = hole_r;
        vwdata = vrdata;
        valid_nxt[hole_r] = 1'b1;
        valid_nxt[s_r]    = 1'b0;
        hole_nxt  = s_r;
        s_nxt     = s_r + 1'b1;
        state_nxt = lpht_pkg::B_ERASE;
      end
      lpht_pkg::B_RESP: begin
        if (!out_valid_r || out_itm.ready) begin
          load_out  = 1'b1;
          state_nxt = lpht_pkg::B_IDLE;
        end
      end
      default: state_nxt = lpht_pkg::B_IDLE;
    endcase
  end

  assign out_itm.valid       = out_valid_r;
  assign out_itm.status      = out_status_r;
  assign out_itm.value_out   = out_vout_r;
  assign out_itm.slot_index  = out_slot_r;
  assign out_itm.entry_count = out_count_r;

  `LPHT_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r < CW'(lpht_pkg::TABLE_SLOTS))
  `LPHT_ASSERT_IMPL(a_count_matches, clk, rst_n, state_r == lpht_pkg::B_IDLE, $countones(valid_r) == int'(count_r))
  `LPHT_ASSERT_IMPL(a_move_distinct, clk, rst_n, state_r == lpht_pkg::B_MOVE, hole_r != s_r)
endmodule
`default_nettype wire

@@ hw/rtl/linear_probe_hash_table.sv @@
// Linear-probing hash table: the hash front end works on one item at a time
// (accept, 6 products of 3 partial products each on one 32x32 multiplier, push),
// then a 2-entry queue. Engine: one probed slot at a time from home, a value read
// for lookup, a slot walk with backward shift on remove, then the result register.
// The front end takes a new item only after pushing its last job into the queue.
// Reset: synchronous; slot valid bits are cleared by reset, no clearing pass.
`default_nettype none
module linear_probe_hash_table (
  input  wire logic clk,
  input  wire logic rst_n,
  lpht_in_if.sink    in_itm,
  lpht_out_if.source out_itm
);
  logic           push_valid, push_ready, pop_valid, pop_ready;
  lpht_pkg::job_t push_job, pop_job;

  lpht_front u_front (
    .clk(clk), .rst_n(rst_n), .in_itm(in_itm),
    .push_valid(push_valid), .push_ready(push_ready), .push_job(push_job)
  );

  lpht_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(push_valid), .push_ready(push_ready), .push_job(push_job),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_job(pop_job)
  );

  lpht_back u_back (
    .clk(clk), .rst_n(rst_n),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_job(pop_job),
    .out_itm(out_itm)
  );
endmodule
`default_nettype wire

@@ tb/tb_linear_probe_hash_table.sv @@
// Self-checking bench for linear_probe_hash_table: directed table, then random traffic.
// Predicts results from its own copy of the slot table and hash, except directed rows with a fixed result.
// Depends on lpht_pkg, lpht_if and the block itself.
`timescale 1ns / 100ps
module tb_linear_probe_hash_table;
  localparam int NSLOT      = 256;
  localparam int POOL_SIZE  = 300;
  localparam int RAND_ITEMS = 730;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    lpht_pkg::status_t status;
    logic [63:0]       value_out;
    logic [7:0]        slot_index;
    logic [8:0]        entry_count;
  } result_t;

  typedef struct {
    lpht_pkg::cmd_t cmd;
    logic [63:0]    key;
    logic [63:0]    value;
    bit             fixed;
    result_t        res;
  } row_t;

  logic clk;
  logic rst_n;
  lpht_in_if  in_ch();
  lpht_out_if out_ch();

  linear_probe_hash_table dut (
    .clk(clk), .rst_n(rst_n), .in_itm(in_ch), .out_itm(out_ch)
  );

  // shadow table
  logic [63:0] tbl_keys [NSLOT];
  logic [63:0] tbl_vals [NSLOT];
  int          tbl_count;

  result_t     pending_results[$];
  logic [63:0] key_pool [POOL_SIZE];
  int          errors;
  int          idle_cycles;
  int          sent_cnt, got_cnt;
  int          status_hits [5];
  int          sender_idle_pct, receiver_stall_pct;
  bit          cur_fixed;
  result_t     cur_fixed_res;

  function automatic logic [63:0] fmix(input logic [63:0] k);
    k = k ^ (k >> 33);
    k = k * 64'hff51afd7ed558ccd;
    k = k ^ (k >> 33);
    k = k * 64'hc4ceb9fe1a85ec53;
    k = k ^ (k >> 33);
    return k;
  endfunction

  function automatic logic [7:0] home_of(input logic [63:0] k);
    logic [63:0] h1, h2, k1;
    h1 = 64'd42;
    h2 = 64'd42;
    k1 = k * 64'h87c37b91114253d5;
    k1 = {k1[32:0], k1[63:33]};
    k1 = k1 * 64'h4cf5ad432745937f;
    h1 = h1 ^ k1;
    h1 = h1 ^ 64'd8;
    h2 = h2 ^ 64'd8;
    h1 = h1 + h2;
    h2 = h2 + h1;
    h1 = fmix(h1);
    h2 = fmix(h2);
    h1 = h1 + h2;
    return h1[7:0];
  endfunction

  function automatic bit locate(input logic [63:0] k, output logic [7:0] where);
    logic [7:0] s;
    s = home_of(k);
    where = '0;
    for (int n = 0; n < NSLOT; n++) begin
      if (tbl_keys[s][7:0] == 8'h00) return 0;
      if (tbl_keys[s] == k) begin
        where = s;
        return 1;
      end
      s = s + 8'd1;
    end
    return 0;
  endfunction

  // backward-shift deletion: pull later cluster members into the hole
  function automatic void close_gap(input logic [7:0] hole);
    logic [7:0] s, h;
    s = hole;
    tbl_keys[hole] = '0;
    for (int n = 0; n < NSLOT; n++) begin
      s = s + 8'd1;
      if (tbl_keys[s][7:0] == 8'h00) break;
      h = home_of(tbl_keys[s]);
      if (8'(s - h) >= 8'(s - hole)) begin
        tbl_keys[hole] = tbl_keys[s];
        tbl_vals[hole] = tbl_vals[s];
        tbl_keys[s] = '0;
        hole = s;
      end
    end
  endfunction

  function automatic result_t apply_command(input lpht_pkg::cmd_t c, input logic [63:0] k,
                                            input logic [63:0] v);
    result_t    r;
    logic [7:0] where, s;
    r.status = lpht_pkg::ST_OK;
    r.value_out = '0;
    r.slot_index = '0;
    if (k[7:0] == 8'h00) begin
      r.status = lpht_pkg::ST_EMPTY_KEY;
    end else if (c == lpht_pkg::CMD_INSERT) begin
      if (locate(k, where)) begin
        r.status = lpht_pkg::ST_PRESENT;
      end else if (tbl_count + 1 >= NSLOT) begin
        r.status = lpht_pkg::ST_FULL;
      end else begin
        s = home_of(k);
        while (tbl_keys[s][7:0] != 8'h00) s = s + 8'd1;
        tbl_keys[s] = k;
        tbl_vals[s] = v;
        tbl_count++;
        r.slot_index = s;
      end
    end else if (!locate(k, where)) begin
      r.status = lpht_pkg::ST_NOT_FOUND;
    end else begin
      r.slot_index = where;
      case (c)
        lpht_pkg::CMD_REMOVE: begin
          close_gap(where);
          tbl_count--;
        end
        lpht_pkg::CMD_LOOKUP: r.value_out = tbl_vals[where];
        default: tbl_vals[where] = v;
      endcase
    end
    r.entry_count = 9'(tbl_count);
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        result_t r;
        r = apply_command(lpht_pkg::cmd_t'(in_ch.cmd), in_ch.key, in_ch.value);
        if (cur_fixed) r = cur_fixed_res;
        pending_results.push_back(r);
        sent_cnt++;
      end
      if (out_ch.valid && out_ch.ready) begin
        result_t e;
        got_cnt++;
        if (pending_results.size() == 0) begin
          $error("unexpected result: status %0d", out_ch.status);
          errors++;
        end else begin
          e = pending_results.pop_front();
          if (out_ch.status < 3'd5) status_hits[out_ch.status]++;
          if (out_ch.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_ch.status);
            errors++;
          end
          if (out_ch.value_out !== e.value_out) begin
            $error("value_out: expected %h, got %h", e.value_out, out_ch.value_out);
            errors++;
          end
          if (out_ch.slot_index !== e.slot_index) begin
            $error("slot_index: expected %0d, got %0d", e.slot_index, out_ch.slot_index);
            errors++;
          end
          if (out_ch.entry_count !== e.entry_count) begin
            $error("entry_count: expected %0d, got %0d", e.entry_count,
                   out_ch.entry_count);
            errors++;
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
        $display("tb_linear_probe_hash_table failed");
        $finish;
      end
    end
  end

  task automatic send_item(input lpht_pkg::cmd_t c, input logic [63:0] k,
                           input logic [63:0] v, input bit fixed, input result_t res);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.cmd = c;
    in_ch.key = k;
    in_ch.value = v;
    cur_fixed = fixed;
    cur_fixed_res = res;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  function automatic result_t typed(input lpht_pkg::status_t st, input logic [7:0] slot,
                                    input logic [8:0] cnt);
    result_t r;
    r.status = st;
    r.value_out = '0;
    r.slot_index = slot;
    r.entry_count = cnt;
    return r;
  endfunction

  initial begin
    row_t           rows[$];
    result_t        none;
    lpht_pkg::cmd_t c;
    logic [63:0]    k;
    int             pick, ins_pct, rem_pct, fresh_pct;
    int             idle_pcts [4];
    int             stall_pcts[4];

    idle_pcts = '{0, 48, 0, 38};
    stall_pcts = '{0, 0, 48, 38};
    errors = 0;
    idle_cycles = 0;
    sent_cnt = 0;
    got_cnt = 0;
    status_hits = '{default: 0};
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    cur_fixed = 1'b0;
    none = typed(lpht_pkg::ST_OK, 8'd0, 9'd0);
    cur_fixed_res = none;
    tbl_count = 0;
    for (int i = 0; i < NSLOT; i++) begin
      tbl_keys[i] = '0;
      tbl_vals[i] = '0;
    end
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = {$urandom, $urandom};
      if (key_pool[i][7:0] == 8'h00) key_pool[i][7:0] = 8'($urandom_range(255, 1));
    end

    in_ch.valid = 1'b0;
    in_ch.cmd = lpht_pkg::CMD_INSERT;
    in_ch.key = '0;
    in_ch.value = '0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    rows = '{
      '{lpht_pkg::CMD_LOOKUP, 64'h1, 64'h0, 1,
        typed(lpht_pkg::ST_NOT_FOUND, 8'd0, 9'd0)},
      '{lpht_pkg::CMD_INSERT, 64'h0, {64{1'b1}}, 1,
        typed(lpht_pkg::ST_EMPTY_KEY, 8'd0, 9'd0)},
      '{lpht_pkg::CMD_REMOVE, 64'hFFFF_FFFF_FFFF_FF00, 64'h0, 1,
        typed(lpht_pkg::ST_EMPTY_KEY, 8'd0, 9'd0)},
      '{lpht_pkg::CMD_UPDATE, 64'h1234_5678_9ABC_DE00, 64'h1, 1,
        typed(lpht_pkg::ST_EMPTY_KEY, 8'd0, 9'd0)},
      '{lpht_pkg::CMD_LOOKUP, 64'hAA00, 64'h0, 1,
        typed(lpht_pkg::ST_EMPTY_KEY, 8'd0, 9'd0)},
      '{lpht_pkg::CMD_INSERT, {64{1'b1}}, {64{1'b1}}, 0, none},
      '{lpht_pkg::CMD_INSERT, 64'h1, 64'h0, 0, none},
      '{lpht_pkg::CMD_INSERT, {64{1'b1}}, 64'h7, 1,
        typed(lpht_pkg::ST_PRESENT, 8'd0, 9'd2)},
      '{lpht_pkg::CMD_LOOKUP, {64{1'b1}}, 64'h0, 0, none},
      '{lpht_pkg::CMD_UPDATE, 64'h1, 64'h5555_5555_5555_5555, 0, none},
      '{lpht_pkg::CMD_LOOKUP, 64'h1, 64'h0, 0, none},
      '{lpht_pkg::CMD_REMOVE, 64'h1, 64'h0, 0, none},
      '{lpht_pkg::CMD_REMOVE, 64'h1, 64'h0, 1,
        typed(lpht_pkg::ST_NOT_FOUND, 8'd0, 9'd1)},
      '{lpht_pkg::CMD_UPDATE, 64'h2, 64'h9, 1,
        typed(lpht_pkg::ST_NOT_FOUND, 8'd0, 9'd1)},
      '{lpht_pkg::CMD_LOOKUP, 64'h2, 64'h0, 1,
        typed(lpht_pkg::ST_NOT_FOUND, 8'd0, 9'd1)},
      '{lpht_pkg::CMD_INSERT, 64'h8000_0000_0000_0001, 64'hAAAA_AAAA_AAAA_AAAA, 0, none},
      '{lpht_pkg::CMD_UPDATE, {64{1'b1}}, 64'h0, 0, none},
      '{lpht_pkg::CMD_LOOKUP, {64{1'b1}}, 64'h0, 0, none},
      '{lpht_pkg::CMD_REMOVE, {64{1'b1}}, 64'h0, 0, none},
      '{lpht_pkg::CMD_LOOKUP, {64{1'b1}}, 64'h0, 0, none},
      '{lpht_pkg::CMD_REMOVE, 64'h8000_0000_0000_0001, 64'h0, 0, none}
    };
    foreach (rows[i]) send_item(rows[i].cmd, rows[i].key, rows[i].value,
                                rows[i].fixed, rows[i].res);

    // phases 0 and 1 insert mostly fresh keys,
    // phase 2 leans on removes, phase 3 mixes everything
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = idle_pcts[ph];
      receiver_stall_pct = stall_pcts[ph];
      ins_pct = (ph == 0) ? 80 : (ph == 1) ? 98 : (ph == 2) ? 20 : 50;
      rem_pct = (ph == 0) ? 5 : (ph == 1) ? 1 : (ph == 2) ? 60 : 25;
      fresh_pct = (ph < 2) ? 60 : 5;
      for (int n = 0; n < RAND_ITEMS / 4; n++) begin
        pick = $urandom_range(99);
        if (pick < ins_pct) c = lpht_pkg::CMD_INSERT;
        else if (pick < ins_pct + rem_pct) c = lpht_pkg::CMD_REMOVE;
        else c = lpht_pkg::cmd_t'($urandom_range(3, 2));
        pick = $urandom_range(99);
        k = key_pool[$urandom_range(POOL_SIZE - 1)];
        if (pick < fresh_pct) k = {$urandom, $urandom};
        else if (pick < fresh_pct + 4) k[7:0] = 8'h00;
        send_item(c, k, {$urandom, $urandom}, 0, none);
      end
    end
    in_ch.valid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("items sent %0d, results checked %0d", sent_cnt, got_cnt);
    $display("status mix ok/missing/present/full/empty: %0d/%0d/%0d/%0d/%0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3],
             status_hits[4]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_linear_probe_hash_table passed");
    end else begin
      $display("tb_linear_probe_hash_table failed");
    end
    $finish;
  end
endmodule
